[hw/rtl/abi_pkg.sv]
// shared types and constants of the axi burst and id issuer
package abi_pkg;

    localparam int ADDR_W      = 48;
    localparam int LINE_BYTES  = 64;
    localparam int BEAT_LOG2   = 6;
    // beat number of a 49-bit byte address
    localparam int BEAT_ADDR_W = ADDR_W + 1 - BEAT_LOG2;
    localparam int Q_DEPTH     = 2;

    localparam logic [2:0] CFG_MAX_OUT   = 3'd0;
    localparam logic [2:0] CFG_MMIO_BASE = 3'd1;
    localparam logic [2:0] CFG_MMIO_LAST = 3'd2;
    localparam logic [2:0] CFG_SCR_BASE  = 3'd3;
    localparam logic [2:0] CFG_SCR_SIZE  = 3'd4;
    localparam logic [2:0] CFG_SCR_BURST = 3'd5;

    typedef enum logic [2:0] {
        ST_ISSUED   = 3'd0,
        ST_BYPASS   = 3'd1,
        ST_STALLED  = 3'd2,
        ST_DONE     = 3'd3,
        ST_BAD_SIZE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        K_REQ      = 2'd0,
        K_BYPASS   = 2'd1,
        K_BAD_SIZE = 2'd2,
        K_DONE     = 2'd3
    } kind_t;

    typedef enum logic {
        BK_LOOK   = 1'b0,
        BK_DECIDE = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [4:0]        id_limit;
        logic [ADDR_W-1:0] mmio_base;
        logic [ADDR_W-1:0] mmio_last;
        logic [ADDR_W-1:0] scratch_base;
        logic [24:0]       scratch_size;
        logic [14:0]       scratch_burst_bytes;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [6:0]        size;
        logic              is_read;
        logic              unmapped;
        logic [15:0]       dest_id;
        logic [3:0]        done_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] burst_addr;
        logic [3:0]        axi_id;
        logic [2:0]        axi_size;
        logic [7:0]        axi_len;
        logic              is_mmio;
        logic              retry_request;
    } out_item_t;

    // classified word handed from the front end to the back end
    typedef struct packed {
        kind_t             kind;
        logic [15:0]       dest_id;
        logic [3:0]        done_id;
        logic [ADDR_W-1:0] burst_addr;
        logic [2:0]        axi_size;
        logic [7:0]        axi_len;
        logic              is_mmio;
    } work_t;

endpackage

[hw/rtl/abi_front.sv]
// front end: address arithmetic and classification of each word
module abi_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  abi_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  abi_pkg::in_item_t  s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output abi_pkg::work_t     q_data
);

    typedef struct packed {
        abi_pkg::in_item_t                   item;
        logic [abi_pkg::ADDR_W:0]            last_b;
        logic [abi_pkg::BEAT_ADDR_W-1:0]     end_beat;
        logic [abi_pkg::BEAT_ADDR_W-1:0]     bend_beat;
        logic [abi_pkg::ADDR_W:0]            limit;
        logic [abi_pkg::ADDR_W:0]            wlast;
    } sums_t;

    typedef struct packed {
        abi_pkg::kind_t                      kind;
        logic [15:0]                         dest_id;
        logic [3:0]                          done_id;
        logic [abi_pkg::ADDR_W-1:0]          addr;
        logic                                size_zero;
        logic                                mmio;
        logic [2:0]                          lg;
        logic                                ext;
        logic                                lim_lt_bend;
        logic [abi_pkg::BEAT_ADDR_W-1:0]     limit_beat;
        logic [abi_pkg::BEAT_ADDR_W-1:0]     bend_beat;
        logic [abi_pkg::BEAT_ADDR_W-1:0]     end_beat;
    } flags_t;

    localparam logic [abi_pkg::ADDR_W:0] ONE_X = (abi_pkg::ADDR_W+1)'(1);

    function automatic logic [2:0] size_log2(input logic [6:0] size);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (size[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    logic              f1_valid_reg, f1_valid_next;
    abi_pkg::in_item_t f1_reg;
    logic              f2_valid_reg, f2_valid_next;
    sums_t             f2_reg, sums_next;
    logic              f3_valid_reg, f3_valid_next;
    flags_t            f3_reg, flags_next;
    logic              f1_free, f2_free, f3_free;

    assign f3_free = !f3_valid_reg || q_ready;
    assign f2_free = !f2_valid_reg || f3_free;
    assign f1_free = !f1_valid_reg || f2_free;
    assign s_ready = f1_free;
    assign q_valid = f3_valid_reg;

    assign f1_valid_next = f1_free ? s_valid : f1_valid_reg;
    assign f2_valid_next = f2_free ? f1_valid_reg : f2_valid_reg;
    assign f3_valid_next = f3_free ? f2_valid_reg : f3_valid_reg;

    // first step: the sums
    logic [abi_pkg::ADDR_W:0] addr_x, size_x, end_sum, sbase_x;
    logic [14:0]              bb_min;
    logic [15:0]              bb_sum;

    always_comb begin
        addr_x  = {1'b0, f1_reg.addr};
        size_x  = (abi_pkg::ADDR_W+1)'(f1_reg.size);
        sbase_x = {1'b0, cfg.scratch_base};
        end_sum = addr_x + size_x + (abi_pkg::ADDR_W+1)'(abi_pkg::LINE_BYTES - 1);
        bb_min  = (cfg.scratch_burst_bytes < 15'(abi_pkg::LINE_BYTES))
                  ? 15'(abi_pkg::LINE_BYTES) : cfg.scratch_burst_bytes;
        bb_sum  = {1'b0, bb_min} + 16'(abi_pkg::LINE_BYTES - 1);

        sums_next.item      = f1_reg;
        sums_next.last_b    = addr_x + size_x - ONE_X;
        sums_next.end_beat  = end_sum[abi_pkg::ADDR_W:abi_pkg::BEAT_LOG2];
        sums_next.bend_beat = {1'b0, f1_reg.addr[abi_pkg::ADDR_W-1:abi_pkg::BEAT_LOG2]}
                              + abi_pkg::BEAT_ADDR_W'(bb_sum[15:abi_pkg::BEAT_LOG2]);
        sums_next.limit     = sbase_x + (abi_pkg::ADDR_W+1)'(cfg.scratch_size);
        sums_next.wlast     = sbase_x + (abi_pkg::ADDR_W+1)'(cfg.scratch_size) - ONE_X;
    end

    // second step: window compares
    logic                     size_zero, win_ok, mmio, bad, touch, lim_lt_bend;
    logic [abi_pkg::ADDR_W:0] end_b, bend_b;

    always_comb begin
        size_zero   = (f2_reg.item.size == 7'd0);
        win_ok      = (cfg.mmio_last >= cfg.mmio_base);
        mmio        = !size_zero && win_ok && !f2_reg.last_b[abi_pkg::ADDR_W]
                      && (f2_reg.item.addr >= cfg.mmio_base)
                      && (f2_reg.last_b[abi_pkg::ADDR_W-1:0] <= cfg.mmio_last);
        bad         = (f2_reg.item.size > 7'(abi_pkg::LINE_BYTES))
                      || ((f2_reg.item.size & (f2_reg.item.size - 7'd1)) != 7'd0);
        touch       = (cfg.scratch_size != 25'd0) && !size_zero
                      && ({1'b0, f2_reg.item.addr} <= f2_reg.wlast)
                      && (f2_reg.last_b >= {1'b0, cfg.scratch_base});
        end_b       = {f2_reg.end_beat, {abi_pkg::BEAT_LOG2{1'b0}}};
        bend_b      = {f2_reg.bend_beat, {abi_pkg::BEAT_LOG2{1'b0}}};
        lim_lt_bend = (f2_reg.limit < bend_b);

        flags_next.kind        = f2_reg.item.op ? abi_pkg::K_DONE
                               : f2_reg.item.unmapped ? abi_pkg::K_BYPASS
                               : (mmio && bad) ? abi_pkg::K_BAD_SIZE
                               : abi_pkg::K_REQ;
        flags_next.dest_id     = f2_reg.item.dest_id;
        flags_next.done_id     = f2_reg.item.done_id;
        flags_next.addr        = f2_reg.item.addr;
        flags_next.size_zero   = size_zero;
        flags_next.mmio        = mmio;
        flags_next.lg          = size_log2(f2_reg.item.size);
        // scratch read reaches past the natural end of the access
        flags_next.ext         = f2_reg.item.is_read && touch
                                 && (lim_lt_bend ? (f2_reg.limit > end_b) : (bend_b > end_b));
        flags_next.lim_lt_bend = lim_lt_bend;
        flags_next.limit_beat  = f2_reg.limit[abi_pkg::ADDR_W:abi_pkg::BEAT_LOG2];
        flags_next.bend_beat   = f2_reg.bend_beat;
        flags_next.end_beat    = f2_reg.end_beat;
    end

    // third step: beat count
    logic [abi_pkg::BEAT_ADDR_W-1:0] eff_beat, span;
    logic [7:0]                      len;

    always_comb begin
        eff_beat = !f3_reg.ext ? f3_reg.end_beat
                 : (f3_reg.lim_lt_bend ? f3_reg.limit_beat : f3_reg.bend_beat);
        span     = eff_beat
                   - {1'b0, f3_reg.addr[abi_pkg::ADDR_W-1:abi_pkg::BEAT_LOG2]}
                   - abi_pkg::BEAT_ADDR_W'(1);
        if (f3_reg.size_zero) begin
            len = 8'd0;
        end else if (|span[abi_pkg::BEAT_ADDR_W-1:8]) begin
            len = 8'hFF;
        end else begin
            len = span[7:0];
        end

        q_data.kind       = f3_reg.kind;
        q_data.dest_id    = f3_reg.dest_id;
        q_data.done_id    = f3_reg.done_id;
        q_data.is_mmio    = f3_reg.mmio;
        q_data.burst_addr = f3_reg.mmio ? f3_reg.addr
                          : {f3_reg.addr[abi_pkg::ADDR_W-1:abi_pkg::BEAT_LOG2],
                             {abi_pkg::BEAT_LOG2{1'b0}}};
        q_data.axi_size   = f3_reg.mmio ? f3_reg.lg : 3'(abi_pkg::BEAT_LOG2);
        q_data.axi_len    = f3_reg.mmio ? 8'd0 : len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
            f3_valid_reg <= f3_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_free) begin
            f1_reg <= s_data;
        end
        if (f2_free) begin
            f2_reg <= sums_next;
        end
        if (f3_free) begin
            f3_reg <= flags_next;
        end
    end

endmodule

[hw/rtl/abi_queue.sv]
// short queue of classified words between front and back end
module abi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  abi_pkg::work_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output abi_pkg::work_t  out_data
);

    localparam int PTR_W = (abi_pkg::Q_DEPTH > 1) ? $clog2(abi_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(abi_pkg::Q_DEPTH + 1);

    abi_pkg::work_t   store_reg [abi_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(abi_pkg::Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(abi_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(abi_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(abi_pkg::Q_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

[hw/rtl/abi_back.sv]
// back end: per-destination id binding, outstanding counts, result register
module abi_back #(
    parameter int ID_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [4:0]         max_out,
    input  logic               q_valid,
    output logic               q_ready,
    input  abi_pkg::work_t     q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output abi_pkg::out_item_t m_data
);

    localparam int IDX_W = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

    function automatic logic [IDX_W-1:0] lowest(input logic [ID_COUNT-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = ID_COUNT - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    abi_pkg::back_state_t state_reg, state_next;
    abi_pkg::work_t       work_reg;
    logic [ID_COUNT-1:0]  match_reg, match_next, free_reg, free_next;
    logic [ID_COUNT-1:0]  bound_reg, bound_next;
    logic [7:0]           count_reg [ID_COUNT];
    logic [15:0]          dest_reg [ID_COUNT];
    logic                 out_valid_reg, out_valid_next;
    abi_pkg::out_item_t   out_reg, result;

    logic             pop, commit;
    logic             found, has_free, done_ok, stall, act, retry;
    logic [IDX_W-1:0] idx;
    logic [7:0]       cur_cnt;
    logic             cur_bound;
    logic             cnt_we, bind_set, bind_clr;
    logic [7:0]       cnt_wdata;

    assign q_ready = pop;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // lookup: compare the destination against every bound entry
    always_comb begin
        for (int i = 0; i < ID_COUNT; i++) begin
            match_next[i] = bound_reg[i] && (dest_reg[i] == q_data.dest_id);
            free_next[i]  = !bound_reg[i] && (32'(i) < 32'(max_out));
        end
    end

    always_comb begin
        found     = |match_reg;
        has_free  = |free_reg;
        done_ok   = (32'(work_reg.done_id) < 32'(ID_COUNT));
        if (work_reg.kind == abi_pkg::K_DONE) begin
            idx = IDX_W'(work_reg.done_id);
        end else if (found) begin
            idx = lowest(match_reg);
        end else begin
            idx = lowest(free_reg);
        end
        cur_cnt   = count_reg[idx];
        cur_bound = bound_reg[idx];
        stall     = found ? (cur_cnt == 8'hFF) : !has_free;
        act       = done_ok && cur_bound && (cur_cnt != 8'd0);
        retry     = act && (cur_cnt == 8'd1);
    end

    always_comb begin
        result = '0;
        unique case (work_reg.kind)
            abi_pkg::K_DONE: begin
                result.status        = abi_pkg::ST_DONE;
                result.axi_id        = work_reg.done_id;
                result.retry_request = retry;
            end
            abi_pkg::K_BYPASS: begin
                result.status = abi_pkg::ST_BYPASS;
            end
            abi_pkg::K_BAD_SIZE: begin
                result.status  = abi_pkg::ST_BAD_SIZE;
                result.is_mmio = 1'b1;
            end
            abi_pkg::K_REQ: begin
                if (stall) begin
                    result.status = abi_pkg::ST_STALLED;
                end else begin
                    result.status     = abi_pkg::ST_ISSUED;
                    result.burst_addr = work_reg.burst_addr;
                    result.axi_id     = 4'(idx);
                    result.axi_size   = work_reg.axi_size;
                    result.axi_len    = work_reg.axi_len;
                    result.is_mmio    = work_reg.is_mmio;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // table updates at the commit of a word
    always_comb begin
        cnt_we    = 1'b0;
        cnt_wdata = cur_cnt;
        bind_set  = 1'b0;
        bind_clr  = 1'b0;
        if (commit) begin
            if (work_reg.kind == abi_pkg::K_REQ && !stall) begin
                cnt_we    = 1'b1;
                cnt_wdata = found ? cur_cnt + 8'd1 : 8'd1;
                bind_set  = !found;
            end else if (work_reg.kind == abi_pkg::K_DONE && act) begin
                cnt_we    = 1'b1;
                cnt_wdata = cur_cnt - 8'd1;
                bind_clr  = retry && (max_out == 5'd1);
            end
        end
    end

    always_comb begin
        bound_next = bound_reg;
        if (bind_set) begin
            bound_next[idx] = 1'b1;
        end
        if (bind_clr) begin
            bound_next[idx] = 1'b0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            abi_pkg::BK_LOOK: begin
                if (q_valid) begin
                    state_next = abi_pkg::BK_DECIDE;
                end
            end
            abi_pkg::BK_DECIDE: begin
                if (commit) begin
                    state_next = abi_pkg::BK_LOOK;
                end
            end
            default: begin
                state_next = abi_pkg::BK_LOOK;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop    = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            abi_pkg::BK_LOOK: begin
                pop = q_valid;
            end
            abi_pkg::BK_DECIDE: begin
                commit = !out_valid_reg || m_ready;
            end
            default: begin
                pop    = 1'b0;
                commit = 1'b0;
            end
        endcase
    end

    assign out_valid_next = commit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= abi_pkg::BK_LOOK;
            bound_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ID_COUNT; i++) begin
                count_reg[i] <= 8'd0;
            end
        end else begin
            state_reg     <= state_next;
            bound_reg     <= bound_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we) begin
                count_reg[idx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            work_reg  <= q_data;
            match_reg <= match_next;
            free_reg  <= free_next;
        end
        if (bind_set) begin
            dest_reg[idx] <= work_reg.dest_id;
        end
        if (commit) begin
            out_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_retry_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.retry_request) |-> (out_reg.status == abi_pkg::ST_DONE))
        else $error("retry raised on a non-completion word");

    a_issued_id_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (result.status == abi_pkg::ST_ISSUED)) |=> bound_reg[$past(idx)])
        else $error("issued id not bound after commit");

    a_stall_keeps_binding: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (result.status == abi_pkg::ST_STALLED)) |=> (bound_reg == $past(bound_reg)))
        else $error("stalled request changed id bindings");
`endif

endmodule

[hw/rtl/axi_burst_and_id_issuer_unit.sv]
// top level of the axi burst and id issuer: configuration registers and the three parts
// an accepted word passes the three front-end steps, the queue, and the back-end
// lookup and commit; the back end takes no new word until it has committed the last
// one, and a commit waits while an unaccepted result still holds m_valid
// reset: synchronous, active low; registers return to their reset values and all
// id bindings and counts clear at once, so no clearing pass is needed
module axi_burst_and_id_issuer_unit #(
    parameter int ID_COUNT = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  abi_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output abi_pkg::out_item_t          m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [abi_pkg::ADDR_W-1:0]  cfg_data
);

    abi_pkg::cfg_t  cfg_reg, cfg_next;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    abi_pkg::work_t fq_data, qb_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                abi_pkg::CFG_MAX_OUT:   cfg_next.id_limit            = cfg_data[4:0];
                abi_pkg::CFG_MMIO_BASE: cfg_next.mmio_base           = cfg_data;
                abi_pkg::CFG_MMIO_LAST: cfg_next.mmio_last           = cfg_data;
                abi_pkg::CFG_SCR_BASE:  cfg_next.scratch_base        = cfg_data;
                abi_pkg::CFG_SCR_SIZE:  cfg_next.scratch_size        = cfg_data[24:0];
                abi_pkg::CFG_SCR_BURST: cfg_next.scratch_burst_bytes = cfg_data[14:0];
                default:                cfg_next                     = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.id_limit            <= 5'd4;
            cfg_reg.mmio_base           <= '0;
            cfg_reg.mmio_last           <= '0;
            cfg_reg.scratch_base        <= '0;
            cfg_reg.scratch_size        <= '0;
            cfg_reg.scratch_burst_bytes <= 15'(abi_pkg::LINE_BYTES);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    abi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    abi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    abi_back #(
        .ID_COUNT (ID_COUNT)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .max_out (cfg_reg.id_limit),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
